@@ hw/rtl/gmdfs_pkg.sv @@
// Package for the grid maze depth-first path finder.
// Holds move codes, visit mark codes and the stack entry layout.
// Used by the step unit and the top level; depends on nothing.
package gmdfs_pkg;

  localparam int CoordW = 3;

  // Move codes, as seen on move_dir and as the 1-based tried direction.
  localparam logic [2:0] MOVE_NONE  = 3'd0;
  localparam logic [2:0] MOVE_NORTH = 3'd1;
  localparam logic [2:0] MOVE_EAST  = 3'd2;
  localparam logic [2:0] MOVE_SOUTH = 3'd3;
  localparam logic [2:0] MOVE_WEST  = 3'd4;

  // Visit marks.
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_PATH = 2'd1;
  localparam logic [1:0] MARK_DEAD = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_ROW = 2'd0;
  localparam logic [1:0] REG_START_COL = 2'd1;
  localparam logic [1:0] REG_GOAL_ROW  = 2'd2;
  localparam logic [1:0] REG_GOAL_COL  = 2'd3;

  // One level of the search stack: cell and number of directions tried.
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [2:0]        dir;
  } stack_entry_t;

  // Cell produced by the neighbor unit.
  typedef struct packed {
    logic              in_grid;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } cell_t;

endpackage

@@ hw/rtl/gmdfs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No package dependency.
module gmdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gmdfs_step_unit.sv @@
// Shared neighbor unit: steps a cell by one move, checks it against the grid
// bounds and forms its linear memory address. Depends on gmdfs_pkg.
module gmdfs_step_unit import gmdfs_pkg::*; #(
  parameter int GRID_ROWS = 8,
  parameter int GRID_COLS = 8
) (
  input  logic [CoordW-1:0]                      row,
  input  logic [CoordW-1:0]                      col,
  input  logic [2:0]                             move,
  output cell_t                                  stepped,
  output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0] addr
);

  localparam int AW = $clog2(GRID_ROWS * GRID_COLS);
  localparam logic [CoordW:0] ROWS_W = (CoordW + 1)'(GRID_ROWS);
  localparam logic [CoordW:0] COLS_W = (CoordW + 1)'(GRID_COLS);

  // One extra bit so that stepping off either edge lands outside the grid.
  logic [CoordW:0]     r_ext;
  logic [CoordW:0]     c_ext;
  logic [2*CoordW+1:0] lin;

  always_comb begin
    r_ext = {1'b0, row};
    c_ext = {1'b0, col};
    case (move)
      MOVE_NORTH: r_ext = r_ext - 1'b1;
      MOVE_EAST:  c_ext = c_ext + 1'b1;
      MOVE_SOUTH: r_ext = r_ext + 1'b1;
      MOVE_WEST:  c_ext = c_ext - 1'b1;
      default: ;
    endcase
    lin = {{(CoordW + 1){1'b0}}, r_ext} * {{(CoordW + 1){1'b0}}, COLS_W}
          + {{(CoordW + 1){1'b0}}, c_ext};
    stepped.in_grid = (r_ext < ROWS_W) && (c_ext < COLS_W);
    stepped.row     = r_ext[CoordW-1:0];
    stepped.col     = c_ext[CoordW-1:0];
    addr            = lin[AW-1:0];
  end

endmodule

@@ hw/rtl/grid_maze_dfs_path_finder_top.sv @@
// Top level of the grid maze depth-first path finder: sequencer, wall map,
// visit marks and search stack. Depends on gmdfs_pkg, gmdfs_ram, gmdfs_step_unit.
//
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// cell in  | start / busy           | cell_row, cell_col, cell_wall, last_cell
// result   | result_valid (strobe)  | path_found, move_dir, to_row, to_col,
//          |                        | last_result
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A cell word without last_cell is taken and busy stays low.
// With last_cell the search runs: setup in S_INIT and S_START, then S_STEP and
// S_CHECK per in-grid neighbor tried, S_STEP alone per neighbor off the grid and
// S_STEP then S_POP per dead-end pop, all through the one neighbor unit and the
// single read port of each memory. A found path streams out move words from
// S_EMIT_RD and S_EMIT_OUT, the final word from S_LAST. Reset is synchronous and
// clears the wall map valid bits, so the block starts with an open grid. Config
// writes wait while busy; the receiver cannot stall results.
module grid_maze_dfs_path_finder_top import gmdfs_pkg::*; #(
  parameter int GRID_ROWS = 8,
  parameter int GRID_COLS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CoordW-1:0] cell_row,
  input  logic [CoordW-1:0] cell_col,
  input  logic              cell_wall,
  input  logic              last_cell,
  output logic              result_valid,
  output logic              path_found,
  output logic [2:0]        move_dir,
  output logic [CoordW-1:0] to_row,
  output logic [CoordW-1:0] to_col,
  output logic              last_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CoordW-1:0] cfg_data
);

  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int TW     = $clog2(NCELLS + 1);
  localparam int SW     = $bits(stack_entry_t);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_INIT     = 10'b0000000010,
    S_START    = 10'b0000000100,
    S_STEP     = 10'b0000001000,
    S_CHECK    = 10'b0000010000,
    S_POP      = 10'b0000100000,
    S_FIRST    = 10'b0001000000,
    S_EMIT_RD  = 10'b0010000000,
    S_EMIT_OUT = 10'b0100000000,
    S_LAST     = 10'b1000000000
  } state_t;

  state_t state;

  logic [CoordW-1:0] start_row;
  logic [CoordW-1:0] start_col;
  logic [CoordW-1:0] goal_row;
  logic [CoordW-1:0] goal_col;

  // Current top of the stack lives in registers; lower levels in the RAM.
  logic [CoordW-1:0] cur_row;
  logic [CoordW-1:0] cur_col;
  logic [2:0]        cur_dir;
  logic [TW-1:0]     top;
  logic [TW-1:0]     idx;
  logic [2:0]        prev_dir;

  logic [CoordW-1:0] nb_row;
  logic [CoordW-1:0] nb_col;
  logic [AW-1:0]     nb_addr;
  logic              start_ok;

  logic [NCELLS-1:0] wall_vld;
  logic [NCELLS-1:0] visit_vld;

  logic [CoordW-1:0] u_row;
  logic [CoordW-1:0] u_col;
  logic [2:0]        u_move;
  cell_t             u_cell;
  logic [AW-1:0]     u_addr;

  logic              wall_we;
  logic              wall_rdata;
  logic              visit_we;
  logic [AW-1:0]     visit_waddr;
  logic [1:0]        visit_wdata;
  logic [1:0]        visit_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  stack_entry_t      stk_wdata;
  logic [AW-1:0]     stk_raddr;
  logic [SW-1:0]     stk_rdata_raw;
  stack_entry_t      stk_rdata;
  logic [TW-1:0]     top_dec;

  logic              nb_blocked;
  logic              start_blocked;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign stk_rdata = stack_entry_t'(stk_rdata_raw);
  assign top_dec   = top - 1'b1;

  assign nb_blocked = (wall_vld[nb_addr] & wall_rdata)
                    | (visit_vld[nb_addr] & (visit_rdata != MARK_FREE));
  assign start_blocked = !start_ok || (wall_vld[nb_addr] & wall_rdata);

  // Neighbor unit input selection.
  always_comb begin
    u_row  = cur_row;
    u_col  = cur_col;
    u_move = (cur_dir >= 3'd4) ? MOVE_NONE : cur_dir + 3'd1;
    case (state)
      S_IDLE: begin
        u_row  = cell_row;
        u_col  = cell_col;
        u_move = MOVE_NONE;
      end
      S_INIT: begin
        u_row  = start_row;
        u_col  = start_col;
        u_move = MOVE_NONE;
      end
      default: ;
    endcase
  end

  gmdfs_step_unit #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_step (
    .row    (u_row),
    .col    (u_col),
    .move   (u_move),
    .stepped(u_cell),
    .addr   (u_addr)
  );

  // Memory port control.
  always_comb begin
    wall_we     = (state == S_IDLE) && start && u_cell.in_grid;
    visit_we    = 1'b0;
    visit_waddr = nb_addr;
    visit_wdata = MARK_PATH;
    stk_we      = 1'b0;
    stk_waddr   = top_dec[AW-1:0];
    stk_wdata   = '{row: cur_row, col: cur_col, dir: cur_dir};
    stk_raddr   = idx[AW-1:0];
    case (state)
      S_START: begin
        visit_we = !start_blocked && !((start_row == goal_row) && (start_col == goal_col));
      end
      S_STEP: begin
        if (cur_dir >= 3'd4) begin
          visit_we    = 1'b1;
          visit_waddr = u_addr;
          visit_wdata = MARK_DEAD;
        end
        stk_raddr = top_dec[AW-1:0] - 1'b1;
      end
      S_CHECK: begin
        if (!nb_blocked && !((nb_row == goal_row) && (nb_col == goal_col))) begin
          visit_we = 1'b1;
          stk_we   = 1'b1;
        end
        stk_raddr = '0;
      end
      default: ;
    endcase
  end

  gmdfs_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_wall_ram (
    .clk  (clk),
    .we   (wall_we),
    .waddr(u_addr),
    .wdata(cell_wall),
    .raddr(u_addr),
    .rdata(wall_rdata)
  );

  gmdfs_ram #(.WIDTH(2), .DEPTH(NCELLS)) u_visit_ram (
    .clk  (clk),
    .we   (visit_we),
    .waddr(visit_waddr),
    .wdata(visit_wdata),
    .raddr(u_addr),
    .rdata(visit_rdata)
  );

  gmdfs_ram #(.WIDTH(SW), .DEPTH(NCELLS)) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata_raw)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_row <= '0;
      start_col <= '0;
      goal_row  <= 3'd7;
      goal_col  <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ROW: start_row <= cfg_data;
        REG_START_COL: start_col <= cfg_data;
        REG_GOAL_ROW:  goal_row  <= cfg_data;
        REG_GOAL_COL:  goal_col  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits: a cell never written reads as open and unvisited.
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_vld  <= '0;
      visit_vld <= '0;
    end else begin
      if (wall_we) begin
        wall_vld[u_addr] <= 1'b1;
      end
      if (state == S_INIT) begin
        visit_vld <= '0;
      end else if (visit_we) begin
        visit_vld[visit_waddr] <= 1'b1;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      top          <= '0;
      idx          <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && last_cell) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          start_ok <= u_cell.in_grid;
          nb_addr  <= u_addr;
          state    <= S_START;
        end
        S_START: begin
          if (start_blocked) begin
            result_valid <= 1'b1;
            path_found   <= 1'b0;
            move_dir     <= MOVE_NONE;
            to_row       <= '0;
            to_col       <= '0;
            last_result  <= 1'b1;
            state        <= S_IDLE;
          end else if ((start_row == goal_row) && (start_col == goal_col)) begin
            result_valid <= 1'b1;
            path_found   <= 1'b1;
            move_dir     <= MOVE_NONE;
            to_row       <= goal_row;
            to_col       <= goal_col;
            last_result  <= 1'b1;
            state        <= S_IDLE;
          end else begin
            cur_row <= start_row;
            cur_col <= start_col;
            cur_dir <= '0;
            top     <= TW'(1);
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          if (cur_dir >= 3'd4) begin
            // Dead end: drop this level and reload the one below.
            top <= top_dec;
            if (top_dec == '0) begin
              result_valid <= 1'b1;
              path_found   <= 1'b0;
              move_dir     <= MOVE_NONE;
              to_row       <= '0;
              to_col       <= '0;
              last_result  <= 1'b1;
              state        <= S_IDLE;
            end else begin
              state <= S_POP;
            end
          end else begin
            cur_dir <= cur_dir + 3'd1;
            nb_row  <= u_cell.row;
            nb_col  <= u_cell.col;
            nb_addr <= u_addr;
            if (u_cell.in_grid) begin
              state <= S_CHECK;
            end
          end
        end
        S_POP: begin
          cur_row <= stk_rdata.row;
          cur_col <= stk_rdata.col;
          cur_dir <= stk_rdata.dir;
          state   <= S_STEP;
        end
        S_CHECK: begin
          if (nb_blocked) begin
            state <= S_STEP;
          end else if ((nb_row == goal_row) && (nb_col == goal_col)) begin
            idx <= TW'(1);
            if (top == TW'(1)) begin
              prev_dir <= cur_dir;
              state    <= S_LAST;
            end else begin
              state <= S_FIRST;
            end
          end else begin
            cur_row <= nb_row;
            cur_col <= nb_col;
            cur_dir <= '0;
            top     <= top + 1'b1;
            state   <= S_STEP;
          end
        end
        S_FIRST: begin
          prev_dir <= stk_rdata.dir;
          state    <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          if (idx == top_dec) begin
            // Next level is the register-held top.
            result_valid <= 1'b1;
            path_found   <= 1'b1;
            move_dir     <= prev_dir;
            to_row       <= cur_row;
            to_col       <= cur_col;
            last_result  <= 1'b0;
            prev_dir     <= cur_dir;
            state        <= S_LAST;
          end else begin
            state <= S_EMIT_OUT;
          end
        end
        S_EMIT_OUT: begin
          result_valid <= 1'b1;
          path_found   <= 1'b1;
          move_dir     <= prev_dir;
          to_row       <= stk_rdata.row;
          to_col       <= stk_rdata.col;
          last_result  <= 1'b0;
          prev_dir     <= stk_rdata.dir;
          idx          <= idx + 1'b1;
          state        <= S_EMIT_RD;
        end
        S_LAST: begin
          result_valid <= 1'b1;
          path_found   <= 1'b1;
          move_dir     <= prev_dir;
          to_row       <= goal_row;
          to_col       <= goal_col;
          last_result  <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb_grid_maze_dfs_path_finder_top.sv @@
// Self-checking testbench for grid_maze_dfs_path_finder_top: loads maze cells,
// triggers searches and checks every move word against a behavioral path planner
// or a typed expected word. Depends on gmdfs_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_grid_maze_dfs_path_finder_top;
  import gmdfs_pkg::*;

  localparam int GRID_ROWS     = 8;
  localparam int GRID_COLS     = 8;
  localparam int ITEM_TARGET   = 330;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic       found;
    logic [2:0] dir;
    logic [2:0] row;
    logic [2:0] col;
    logic       is_last;
  } move_word_t;

  typedef enum logic [1:0] {ROW_CELL, ROW_CELL_CHECKED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] reg_index;
    logic [2:0] reg_value;
    logic [2:0] row;
    logic [2:0] col;
    logic       wall;
    logic       is_last;
    move_word_t word;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CoordW-1:0] cell_row = '0;
  logic [CoordW-1:0] cell_col = '0;
  logic              cell_wall = 1'b0;
  logic              last_cell = 1'b0;
  logic              result_valid;
  logic              path_found;
  logic [2:0]        move_dir;
  logic [CoordW-1:0] to_row;
  logic [CoordW-1:0] to_col;
  logic              last_result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CoordW-1:0] cfg_data = '0;

  // Planner state: wall map and registers as the block should hold them.
  logic [GRID_ROWS*GRID_COLS-1:0] wall_map_q;
  logic [2:0] start_row_q, start_col_q, goal_row_q, goal_col_q;
  move_word_t expected_moves [$];
  stim_row_t  directed_rows [$];
  move_word_t got_word, want_word;
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;

  grid_maze_dfs_path_finder_top #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cell_row(cell_row), .cell_col(cell_col), .cell_wall(cell_wall), .last_cell(last_cell),
    .result_valid(result_valid), .path_found(path_found), .move_dir(move_dir),
    .to_row(to_row), .to_col(to_col), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic move_word_t make_word(logic found, logic [2:0] dir, logic [2:0] row,
                                           logic [2:0] col, logic is_last);
    make_word = {found, dir, row, col, is_last};
  endfunction

  function automatic void queue_word(move_word_t w);
    expected_moves.insert(expected_moves.size(), w);
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic stim_row_t cell_op(logic [2:0] row, logic [2:0] col, logic wall,
                                        logic is_last);
    cell_op = '0;
    cell_op.kind = ROW_CELL;
    cell_op.row = row;
    cell_op.col = col;
    cell_op.wall = wall;
    cell_op.is_last = is_last;
  endfunction

  function automatic stim_row_t cell_chk(logic [2:0] row, logic [2:0] col, logic wall,
                                         logic is_last, move_word_t word);
    cell_chk = cell_op(row, col, wall, is_last);
    cell_chk.kind = ROW_CELL_CHECKED;
    cell_chk.word = word;
  endfunction

  function automatic stim_row_t reg_op(logic [1:0] index, logic [2:0] value);
    reg_op = '0;
    reg_op.kind = ROW_REG;
    reg_op.reg_index = index;
    reg_op.reg_value = value;
  endfunction

  function automatic logic [2:0] edge_biased_coord();
    if ($urandom_range(0, 3) == 0)
      edge_biased_coord = ($urandom_range(0, 1) == 1) ? 3'd7 : 3'd0;
    else
      edge_biased_coord = 3'($urandom_range(0, 7));
  endfunction

  // Depth-first search with an explicit stack, neighbors tried north, east,
  // south, west. Cells popped as dead ends stay blocked for the whole search.
  task automatic plan_path();
    logic [1:0] mark [GRID_ROWS*GRID_COLS];
    int srow [GRID_ROWS*GRID_COLS];
    int scol [GRID_ROWS*GRID_COLS];
    int tried [GRID_ROWS*GRID_COLS];
    int top, nr, nc, nbr, i;
    bit found;
    move_word_t w;
    for (i = 0; i < GRID_ROWS*GRID_COLS; i++) mark[i] = MARK_FREE;
    if (wall_map_q[int'(start_row_q)*GRID_COLS + int'(start_col_q)]) begin
      queue_word(make_word(1'b0, MOVE_NONE, 3'd0, 3'd0, 1'b1));
      return;
    end
    if (start_row_q == goal_row_q && start_col_q == goal_col_q) begin
      queue_word(make_word(1'b1, MOVE_NONE, goal_row_q, goal_col_q, 1'b1));
      return;
    end
    mark[int'(start_row_q)*GRID_COLS + int'(start_col_q)] = MARK_PATH;
    srow[0] = int'(start_row_q);
    scol[0] = int'(start_col_q);
    tried[0] = 0;
    top = 1;
    found = 1'b0;
    while (top > 0 && !found) begin
      if (tried[top-1] >= 4) begin
        mark[srow[top-1]*GRID_COLS + scol[top-1]] = MARK_DEAD;
        top = top - 1;
      end else begin
        nr = srow[top-1];
        nc = scol[top-1];
        case (tried[top-1])
          0: nr = nr - 1;
          1: nc = nc + 1;
          2: nr = nr + 1;
          default: nc = nc - 1;
        endcase
        tried[top-1] = tried[top-1] + 1;
        if (nr >= 0 && nr < GRID_ROWS && nc >= 0 && nc < GRID_COLS) begin
          nbr = nr*GRID_COLS + nc;
          if (!wall_map_q[nbr] && mark[nbr] == MARK_FREE) begin
            if (nr == int'(goal_row_q) && nc == int'(goal_col_q)) begin
              found = 1'b1;
            end else begin
              mark[nbr] = MARK_PATH;
              srow[top] = nr;
              scol[top] = nc;
              tried[top] = 0;
              top = top + 1;
            end
          end
        end
      end
    end
    if (!found) begin
      queue_word(make_word(1'b0, MOVE_NONE, 3'd0, 3'd0, 1'b1));
      return;
    end
    // The direction last tried at each level is the move out of that level.
    for (i = 0; i < top; i++) begin
      w.found = 1'b1;
      case (tried[i])
        1: w.dir = MOVE_NORTH;
        2: w.dir = MOVE_EAST;
        3: w.dir = MOVE_SOUTH;
        default: w.dir = MOVE_WEST;
      endcase
      w.is_last = (i + 1 == top);
      w.row = w.is_last ? goal_row_q : 3'(srow[i+1]);
      w.col = w.is_last ? goal_col_q : 3'(scol[i+1]);
      queue_word(w);
    end
  endtask

  // Sender bursts: random length, random gaps, sometimes none at all.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Leaves start high after acceptance; the caller lowers it or sends again.
  task automatic send_cell(logic [2:0] row, logic [2:0] col, logic wall, logic is_last,
                           bit checked, move_word_t typed_word);
    start <= 1'b1;
    cell_row <= row;
    cell_col <= col;
    cell_wall <= wall;
    last_cell <= is_last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    wall_map_q[int'(row)*GRID_COLS + int'(col)] = wall;
    items_sent++;
    if (is_last) begin
      if (checked) queue_word(typed_word);
      else plan_path();
    end
  endtask

  // Wait until the block is idle so that registers may be written.
  task automatic settle();
    start <= 1'b0;
    while (expected_moves.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [2:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (index)
      REG_START_ROW: start_row_q = value;
      REG_START_COL: start_col_q = value;
      REG_GOAL_ROW:  goal_row_q = value;
      REG_GOAL_COL:  goal_col_q = value;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      got_word = {path_found, move_dir, to_row, to_col, last_result};
      if (expected_moves.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual found=%0d dir=%0d",
                 $time, got_word.found, got_word.dir,
                 " row=%0d col=%0d last=%0d", got_word.row, got_word.col, got_word.is_last);
      end else begin
        want_word = expected_moves.pop_front();
        if (got_word !== want_word) begin
          errors++;
          $display("%0t: result word mismatch, expected found=%0d dir=%0d row=%0d col=%0d",
                   $time, want_word.found, want_word.dir, want_word.row, want_word.col,
                   " last=%0d, actual found=%0d dir=%0d row=%0d col=%0d last=%0d",
                   want_word.is_last, got_word.found, got_word.dir, got_word.row,
                   got_word.col, got_word.is_last);
        end
      end
    end
  end

  initial begin
    int n;
    bit wall_heavy;
    int wall_odds;
    move_word_t no_path;
    no_path = make_word(1'b0, MOVE_NONE, 3'd0, 3'd0, 1'b1);
    wall_map_q = '0;
    start_row_q = 3'd0;
    start_col_q = 3'd0;
    goal_row_q = 3'd7;
    goal_col_q = 3'd7;

    // Open grid from corner to corner, then start on the goal, walls on the
    // start and goal (a walled goal makes the search sweep the whole grid),
    // a boxed-in start, and boxed-in and walled cases in the other corners.
    add_row(cell_op(3'd3, 3'd4, 1'b0, 1'b0));
    add_row(cell_op(3'd7, 3'd7, 1'b0, 1'b1));
    add_row(reg_op(REG_GOAL_ROW, 3'd0));
    add_row(reg_op(REG_GOAL_COL, 3'd0));
    add_row(cell_chk(3'd0, 3'd0, 1'b0, 1'b1,
                     make_word(1'b1, MOVE_NONE, 3'd0, 3'd0, 1'b1)));
    add_row(cell_chk(3'd0, 3'd0, 1'b1, 1'b1, no_path));
    add_row(cell_op(3'd0, 3'd0, 1'b0, 1'b0));
    add_row(reg_op(REG_START_ROW, 3'd7));
    add_row(reg_op(REG_START_COL, 3'd7));
    add_row(cell_op(3'd5, 3'd2, 1'b0, 1'b1));
    add_row(cell_chk(3'd0, 3'd0, 1'b1, 1'b1, no_path));
    add_row(cell_op(3'd0, 3'd0, 1'b0, 1'b0));
    add_row(cell_op(3'd6, 3'd7, 1'b1, 1'b0));
    add_row(cell_chk(3'd7, 3'd6, 1'b1, 1'b1, no_path));
    add_row(cell_op(3'd6, 3'd7, 1'b0, 1'b0));
    add_row(cell_op(3'd7, 3'd6, 1'b0, 1'b0));
    add_row(reg_op(REG_START_ROW, 3'd0));
    add_row(reg_op(REG_START_COL, 3'd7));
    add_row(reg_op(REG_GOAL_ROW, 3'd7));
    add_row(reg_op(REG_GOAL_COL, 3'd0));
    add_row(cell_op(3'd0, 3'd6, 1'b1, 1'b0));
    add_row(cell_chk(3'd1, 3'd7, 1'b1, 1'b1, no_path));
    add_row(cell_op(3'd1, 3'd7, 1'b0, 1'b0));
    add_row(cell_op(3'd4, 3'd3, 1'b1, 1'b1));
    add_row(cell_chk(3'd7, 3'd0, 1'b1, 1'b1, no_path));
    add_row(cell_op(3'd7, 3'd0, 1'b0, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_REG) begin
        if (k == 0 || directed_rows[k-1].kind != ROW_REG) settle();
        write_reg(directed_rows[k].reg_index, directed_rows[k].reg_value);
      end else begin
        cfg_valid <= 1'b0;
        pace();
        send_cell(directed_rows[k].row, directed_rows[k].col, directed_rows[k].wall,
                  directed_rows[k].is_last, directed_rows[k].kind == ROW_CELL_CHECKED,
                  directed_rows[k].word);
      end
    end

    // Each search: a few random cell words, then one with last_cell set.
    // The wall density changes from search to search so that the map drifts
    // between open mazes and cluttered ones.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        settle();
        repeat ($urandom_range(1, 4))
          write_reg(2'($urandom_range(0, 3)), edge_biased_coord());
        cfg_valid <= 1'b0;
      end
      wall_heavy = ($urandom_range(0, 2) == 0);
      wall_odds = wall_heavy ? 2 : $urandom_range(5, 12);
      n = $urandom_range(0, 8);
      for (int j = 0; j <= n; j++) begin
        pace();
        send_cell(edge_biased_coord(), edge_biased_coord(),
                  ($urandom_range(0, wall_odds - 1) == 0), (j == n), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
